// ===== design/mke_pkg.sv =====
// ----------------------------------------------------------------------------
// mke_pkg
// Shared types, constants and helpers of the Matsubara kernel entry pipeline.
// ----------------------------------------------------------------------------
package mke_pkg;

	localparam int unsigned PHASE_BITS_DEF = 32;
	localparam int unsigned TRIG_BITS_DEF  = 18;

	localparam logic [31:0] INV_BETA_RESET = 32'h0001_0000;
	localparam logic [31:0] ONE_Q31        = 32'h8000_0000;
	localparam logic [31:0] PI4_Q32        = 32'hC90F_DAA2;
	localparam int unsigned TAYLOR_STEPS   = 5;

	// Horner divisors for sine and cosine, first step first
	localparam logic [7:0] DIV_SIN [TAYLOR_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [7:0] DIV_COS [TAYLOR_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

	// floor(2^32 / d) reciprocals for the divisors above
	localparam logic [31:0] MAG_SIN [TAYLOR_STEPS] = '{
		32'((33'd1 << 32) / 33'd110), 32'((33'd1 << 32) / 33'd72),
		32'((33'd1 << 32) / 33'd42),  32'((33'd1 << 32) / 33'd20),
		32'((33'd1 << 32) / 33'd6)};
	localparam logic [31:0] MAG_COS [TAYLOR_STEPS] = '{
		32'((33'd1 << 32) / 33'd132), 32'((33'd1 << 32) / 33'd90),
		32'((33'd1 << 32) / 33'd56),  32'((33'd1 << 32) / 33'd30),
		32'((33'd1 << 32) / 33'd12)};

	typedef struct packed {
		logic        kind;
		logic        wneg;
		logic [31:0] wmag;
		logic [2:0]  oct;
	} mke_tag_t;

	// Quotient by a small constant: reciprocal estimate is low by at most one.
	function automatic logic [30:0] div_const(input logic [30:0] x, input logic [31:0] m,
			input logic [7:0] d);
		logic [61:0] prod;
		logic [30:0] est;
		logic [38:0] back;
		logic [31:0] rem;
		prod = 62'(x) * 62'(m);
		est  = 31'(prod >> 32);
		back = 39'(est) * 39'(d);
		rem  = 32'(39'(x) - back);
		if (rem >= 32'(d)) begin
			est = est + 31'd1;
		end
		return est;
	endfunction

endpackage

// ===== design/mke_phase.sv =====
// ----------------------------------------------------------------------------
// mke_phase
// Fraction, phase in turns, octant fold and conversion to an angle in unsigned Q0.31.
// ----------------------------------------------------------------------------
module mke_phase import mke_pkg::*; #(
	parameter int unsigned PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic        kind,
	input  logic [31:0] freq_index,
	input  logic [31:0] time_point,
	input  logic [31:0] weight,
	input  logic [31:0] inverse_beta,
	output logic        out_valid,
	output logic [30:0] theta,
	output mke_tag_t    tag
);

	localparam int unsigned KEEP = (PHASE_BITS < 33) ? PHASE_BITS : 33;
	localparam logic [32:0] PH_MASK = ~((33'd1 << (33 - KEEP)) - 33'd1);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [32:0] frac_s1, mult_s1, q_s2, rr_s3;
	logic [30:0] theta_s4;
	mke_tag_t    tag_s1, tag_s2, tag_s3, tag_s4;
	logic [63:0] frac_full;
	logic [65:0] q_full;
	logic [64:0] th_full;

	assign frac_full = 64'(time_point) * 64'(inverse_beta);
	assign q_full    = 66'(mult_s1) * 66'(frac_s1);
	assign th_full   = 65'(rr_s3) * 65'(PI4_Q32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s1     <= frac_full[32:0];
			// 2n + kind is the index with kind appended
			mult_s1     <= {freq_index, kind};
			tag_s1.kind <= kind;
			tag_s1.wneg <= weight[31];
			tag_s1.wmag <= weight[31] ? (32'd0 - weight) : weight;
			tag_s1.oct  <= '0;

			q_s2   <= q_full[32:0] & PH_MASK;
			tag_s2 <= tag_s1;

			tag_s3 <= {tag_s2.kind, tag_s2.wneg, tag_s2.wmag, q_s2[32:30]};
			// odd octants measure the angle back from the octant end
			if (q_s2[30]) begin
				rr_s3 <= 33'h1_0000_0000 - {1'b0, q_s2[29:0], 2'b00};
			end else begin
				rr_s3 <= {1'b0, q_s2[29:0], 2'b00};
			end

			theta_s4 <= th_full[63:33];
			tag_s4   <= tag_s3;
		end
	end

	assign out_valid = v_s4;
	assign theta     = theta_s4;
	assign tag       = tag_s4;

endmodule

// ===== design/mke_trig.sv =====
// ----------------------------------------------------------------------------
// mke_trig
// Octant sine and cosine by Horner series, one multiply or divide per stage.
// ----------------------------------------------------------------------------
module mke_trig import mke_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [30:0] theta,
	input  mke_tag_t    tag_in,
	output logic        out_valid,
	output logic [31:0] sin_q31,
	output logic [30:0] cos_prod,
	output mke_tag_t    tag_out
);

	localparam int unsigned NST = 2 * TAYLOR_STEPS + 1;

	logic        v_s   [1:NST];
	logic [30:0] th_s  [1:NST];
	logic [30:0] t2_s  [1:NST];
	mke_tag_t    tag_s [1:NST];
	logic [31:0] us_s  [TAYLOR_STEPS];
	logic [31:0] uc_s  [TAYLOR_STEPS];
	logic [30:0] ps_s  [1:TAYLOR_STEPS-1];
	logic [30:0] pc_s  [1:TAYLOR_STEPS-1];
	logic [31:0] sin_s;
	logic [30:0] cp_s;
	logic [61:0] sq_full;
	logic [62:0] sin_full, cos_full;

	assign sq_full  = 62'(theta) * 62'(theta);
	assign sin_full = 63'(th_s[NST-1]) * 63'(us_s[TAYLOR_STEPS-1]);
	assign cos_full = 63'(t2_s[NST-1]) * 63'(uc_s[TAYLOR_STEPS-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= NST; j++) begin
				v_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int j = 2; j <= NST; j++) begin
				v_s[j] <= v_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s[1]  <= theta;
			t2_s[1]  <= sq_full[61:31];
			tag_s[1] <= tag_in;
			for (int j = 2; j <= NST; j++) begin
				th_s[j]  <= th_s[j-1];
				t2_s[j]  <= t2_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
			sin_s <= {1'b0, sin_full[61:31]};
			cp_s  <= cos_full[61:31];
		end
	end

	// first divide step works on t2 directly
	always_ff @(posedge clk) begin
		if (en) begin
			us_s[0] <= ONE_Q31 - 32'(div_const(t2_s[1], MAG_SIN[0], DIV_SIN[0]));
			uc_s[0] <= ONE_Q31 - 32'(div_const(t2_s[1], MAG_COS[0], DIV_COS[0]));
		end
	end

	for (genvar k = 1; k < TAYLOR_STEPS; k++) begin : g_step
		logic [62:0] ms, mc;
		assign ms = 63'(t2_s[2*k]) * 63'(us_s[k-1]);
		assign mc = 63'(t2_s[2*k]) * 63'(uc_s[k-1]);
		always_ff @(posedge clk) begin
			if (en) begin
				ps_s[k] <= ms[61:31];
				pc_s[k] <= mc[61:31];
				us_s[k] <= ONE_Q31 - 32'(div_const(ps_s[k], MAG_SIN[k], DIV_SIN[k]));
				uc_s[k] <= ONE_Q31 - 32'(div_const(pc_s[k], MAG_COS[k], DIV_COS[k]));
			end
		end
	end

	assign out_valid = v_s[NST];
	assign sin_q31   = sin_s;
	assign cos_prod  = cp_s;
	assign tag_out   = tag_s[NST];

endmodule

// ===== design/mke_scale.sv =====
// ----------------------------------------------------------------------------
// mke_scale
// Rounding to trig width, quadrant signs, scaling and Q16.16 saturation.
// ----------------------------------------------------------------------------
module mke_scale import mke_pkg::*; #(
	parameter int unsigned TRIG_BITS = TRIG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] sin_q31,
	input  logic [30:0] cos_prod,
	input  mke_tag_t    tag_in,
	input  logic [31:0] inverse_beta,
	output logic        out_valid,
	output logic [31:0] real_part,
	output logic [31:0] imag_part,
	output logic        saturated
);

	localparam int unsigned SH    = 33 - TRIG_BITS;
	localparam int unsigned TFRAC = TRIG_BITS - 2;

	logic                 v_s1, v_s2, v_s3;
	logic [TRIG_BITS-1:0] cm_s1, sm_s1;
	logic                 cn_s1, sn_s1;
	mke_tag_t             tag_s1;
	logic [63:0]          pr_s2, pi_s2;
	logic                 rn_s2, in_s2;
	logic [31:0]          re_s3, im_s3;
	logic                 sat_s3;

	logic [31:0]          cos_v;
	logic [TRIG_BITS-1:0] c_r, s_r, cq, sq;
	logic [31:0]          amag;
	logic [63:0]          rmag, imag_m;
	logic [31:0]          re_n, im_n;
	logic                 re_sat, im_sat;

	function automatic logic [TRIG_BITS-1:0] to_trig(input logic [31:0] v);
		logic [32:0] t;
		t = 33'(v) + (33'd1 << (SH - 1));
		return TRIG_BITS'(t >> SH);
	endfunction

	function automatic logic [32:0] sat32(input logic neg, input logic [63:0] mag);
		// result bit 32 flags a clip
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				return {1'b1, 32'h8000_0000};
			end
			return {1'b0, 32'(64'd0 - mag)};
		end
		if (mag > 64'h7FFF_FFFF) begin
			return {1'b1, 32'h7FFF_FFFF};
		end
		return {1'b0, mag[31:0]};
	endfunction

	assign cos_v = ONE_Q31 - 32'(cos_prod >> 1);
	assign c_r   = to_trig(cos_v);
	assign s_r   = to_trig(sin_q31);
	assign cq    = tag_in.oct[0] ? s_r : c_r;
	assign sq    = tag_in.oct[0] ? c_r : s_r;
	assign amag  = tag_s1.kind ? tag_s1.wmag : inverse_beta;

	assign rmag   = (pr_s2 + (64'd1 << (TFRAC - 1))) >> TFRAC;
	assign imag_m = (pi_s2 + (64'd1 << (TFRAC - 1))) >> TFRAC;
	assign {re_sat, re_n} = sat32(rn_s2, rmag);
	assign {im_sat, im_n} = sat32(in_s2, imag_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_in;
			case (tag_in.oct[2:1])
				2'd0: begin
					cm_s1 <= cq; cn_s1 <= 1'b0; sm_s1 <= sq; sn_s1 <= 1'b0;
				end
				2'd1: begin
					cm_s1 <= sq; cn_s1 <= 1'b1; sm_s1 <= cq; sn_s1 <= 1'b0;
				end
				2'd2: begin
					cm_s1 <= cq; cn_s1 <= 1'b1; sm_s1 <= sq; sn_s1 <= 1'b1;
				end
				default: begin
					cm_s1 <= sq; cn_s1 <= 1'b0; sm_s1 <= cq; sn_s1 <= 1'b1;
				end
			endcase

			pr_s2 <= 64'(amag) * 64'(cm_s1);
			pi_s2 <= 64'(amag) * 64'(sm_s1);
			if (tag_s1.kind) begin
				rn_s2 <= tag_s1.wneg ^ cn_s1;
				in_s2 <= tag_s1.wneg ^ sn_s1;
			end else begin
				// bosonic entry is conjugated
				rn_s2 <= cn_s1;
				in_s2 <= !sn_s1 && (sm_s1 != '0);
			end

			re_s3  <= re_n;
			im_s3  <= im_n;
			sat_s3 <= re_sat | im_sat;
		end
	end

	assign out_valid = v_s3;
	assign real_part = re_s3;
	assign imag_part = im_s3;
	assign saturated = sat_s3;

endmodule

// ===== design/matsubara_kernel_entry_core.sv =====
// ----------------------------------------------------------------------------
// matsubara_kernel_entry_core
// Matsubara transform kernel entry generator, one complex entry per item.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata {weight, time_point, freq_index}, tuser kind
// m_axis    out        tdata {pad, saturated, imag_part, real_part}
// cfg       in         data = inverse_beta, unsigned Q16.16
//
// One item per cycle while m_axis does not stall (4 phase, 11 series, 3 scale stages).
// The series depth, one multiply or constant divide per stage, sets latency.
// Reset clears all valid bits and loads inverse_beta with 1.0.
// A stall at m_axis freezes every stage at once; s_axis_tready follows it.
// ----------------------------------------------------------------------------
module matsubara_kernel_entry_core import mke_pkg::*; #(
	parameter int unsigned PHASE_BITS = PHASE_BITS_DEF,
	parameter int unsigned TRIG_BITS  = TRIG_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // freq_index, time_point, weight
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // real_part, imag_part, saturated, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic        en;
	logic [31:0] inv_beta_q;
	logic        ph_v, tr_v;
	logic [30:0] theta;
	mke_tag_t    ph_tag, tr_tag;
	logic [31:0] sin_q31;
	logic [30:0] cos_prod;
	logic [31:0] real_part, imag_part;
	logic        saturated;

	// advance whenever the output register is empty or being drained
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_beta_q <= INV_BETA_RESET;
		end else if (cfg_valid) begin
			inv_beta_q <= cfg_data;
		end
	end

	mke_phase #(.PHASE_BITS(PHASE_BITS)) u_phase (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.kind         (s_axis_tuser),
		.freq_index   (s_axis_tdata[31:0]),
		.time_point   (s_axis_tdata[63:32]),
		.weight       (s_axis_tdata[95:64]),
		.inverse_beta (inv_beta_q),
		.out_valid    (ph_v),
		.theta        (theta),
		.tag          (ph_tag)
	);

	mke_trig u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (ph_v),
		.theta     (theta),
		.tag_in    (ph_tag),
		.out_valid (tr_v),
		.sin_q31   (sin_q31),
		.cos_prod  (cos_prod),
		.tag_out   (tr_tag)
	);

	mke_scale #(.TRIG_BITS(TRIG_BITS)) u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (tr_v),
		.sin_q31      (sin_q31),
		.cos_prod     (cos_prod),
		.tag_in       (tr_tag),
		.inverse_beta (inv_beta_q),
		.out_valid    (m_axis_tvalid),
		.real_part    (real_part),
		.imag_part    (imag_part),
		.saturated    (saturated)
	);

	assign m_axis_tdata = {7'd0, saturated, imag_part, real_part};

endmodule
